/* hdl/polygon_arc_segmenter_core_macros.svh */
// Assertion macros shared by the segmenter RTL.
`ifndef POLYGON_ARC_SEGMENTER_CORE_MACROS_SVH
`define POLYGON_ARC_SEGMENTER_CORE_MACROS_SVH
`ifndef SYNTH
// Checked property, switched off while reset is high.
`define PAS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked property that also holds through reset.
`define PAS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PAS_ASSERT(label, prop, msg)
`define PAS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* hdl/pas_pkg.sv */
// Types, widths and constants of the polygon arc segmenter.
package pas_pkg;

   localparam int COORD_BITS     = 12;
   localparam int INDEX_BITS     = 16;
   localparam int SEG_BITS       = 16;
   localparam int FRAC_BITS      = 16;
   localparam int EDGE_BITS      = COORD_BITS + 1;
   localparam int PROD_BITS      = 2 * EDGE_BITS;
   localparam int DOT_BITS       = PROD_BITS + 1;
   localparam int LEN_BITS       = 2 * COORD_BITS + 1;
   localparam int COT_BITS       = 22;
   localparam int LEN_RATIO_BITS = 24;
   localparam int INV_RATIO_BITS = 17;
   localparam int COT_PROD_BITS  = COT_BITS + LEN_BITS;
   localparam int LO_BITS        = INV_RATIO_BITS + LEN_BITS;
   localparam int HI_BITS        = LEN_RATIO_BITS + LEN_BITS;
   localparam int CMP_BITS       = HI_BITS;
   localparam int CSR_DATA_BITS  = 24;
   localparam int CSR_INDEX_BITS = 2;

   // Queue depths must be powers of two; the pointers wrap naturally.
   localparam int CMD_DEPTH      = 2;
   localparam int CMD_PTR_BITS   = $clog2(CMD_DEPTH);
   localparam int CMD_COUNT_BITS = CMD_PTR_BITS + 1;
   localparam int OUT_DEPTH      = 4;
   localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);
   localparam int OUT_COUNT_BITS = OUT_PTR_BITS + 1;

   localparam logic [COT_BITS-1:0]       COT_RESET       = COT_BITS'(37837);
   localparam logic [LEN_RATIO_BITS-1:0] LEN_RATIO_RESET = LEN_RATIO_BITS'(1048576);
   localparam logic [INV_RATIO_BITS-1:0] INV_RATIO_RESET = INV_RATIO_BITS'(4096);

   localparam logic signed [1:0] DIR_NONE = 2'sb00;
   localparam logic signed [1:0] DIR_POS  = 2'sb01;
   localparam logic signed [1:0] DIR_NEG  = 2'sb11;
   localparam logic signed [1:0] DIR_BAD  = 2'sb10;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COT       = 2'd0,
      CSR_LEN_RATIO = 2'd1,
      CSR_INV_RATIO = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CLS_FIRST,
      CLS_SECOND,
      CLS_TURN
   } cls_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DEC
   } bk_state_type;

   typedef struct packed {
      logic [COT_BITS-1:0]       cot;
      logic [LEN_RATIO_BITS-1:0] len_ratio;
      logic [INV_RATIO_BITS-1:0] inv_ratio;
   } cfg_type;

   typedef struct packed {
      logic signed [DOT_BITS-1:0] dot;
      logic signed [DOT_BITS-1:0] crs;
      logic [LEN_BITS-1:0]        len_a;
      logic [LEN_BITS-1:0]        len_b;
      logic [INDEX_BITS-1:0]      k;
      cls_type                    cls;
      logic                       last;
   } cmd_type;

   typedef struct packed {
      logic [SEG_BITS-1:0] seg_start;
      logic [SEG_BITS-1:0] seg_end;
      logic signed [1:0]   seg_dir;
      logic                seg_last;
   } seg_type;

endpackage

/* hdl/pas_req_if.sv */
// Vertex channel: valid/ready handshake with one contour vertex per word.
interface pas_req_if;
   import pas_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] vertex_x;
   logic [COORD_BITS-1:0] vertex_y;
   logic                  last_vertex;

   modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
   modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

/* hdl/pas_rsp_if.sv */
// Segment channel: valid/ready handshake with one segment per word.
interface pas_rsp_if;
   import pas_pkg::*;

   logic                valid;
   logic                ready;
   logic [SEG_BITS-1:0] seg_start;
   logic [SEG_BITS-1:0] seg_end;
   logic signed [1:0]   seg_dir;
   logic                seg_last;

   modport source (output valid, seg_start, seg_end, seg_dir, seg_last, input ready);
   modport sink (input valid, seg_start, seg_end, seg_dir, seg_last, output ready);
endinterface

/* hdl/pas_front.sv */
// Front end: accepts vertices, tracks edges and index, forms the edge products.
module pas_front (
   input  logic             clock,
   input  logic             reset,
   pas_req_if.sink          req_ch,
   output logic             cmd_valid,
   output pas_pkg::cmd_type cmd,
   input  logic             cmd_ready
);
   import pas_pkg::*;

   logic [COORD_BITS-1:0]        prev_vx_ff, prev_vx_in;
   logic [COORD_BITS-1:0]        prev_vy_ff, prev_vy_in;
   logic signed [EDGE_BITS-1:0]  prev_dx_ff, prev_dx_in;
   logic signed [EDGE_BITS-1:0]  prev_dy_ff, prev_dy_in;
   logic [INDEX_BITS-1:0]        count_ff, count_in;

   logic                         s1_valid_ff, s1_valid_in;
   logic signed [EDGE_BITS-1:0]  s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic [INDEX_BITS-1:0]        s1_k_ff;
   cls_type                      s1_cls_ff;
   logic                         s1_last_ff;

   logic                         accept;
   logic signed [EDGE_BITS-1:0]  bx, by;
   cls_type                      cls;
   logic signed [PROD_BITS-1:0]  p_axbx, p_ayby, p_axby, p_aybx;
   logic signed [PROD_BITS-1:0]  p_axax, p_ayay, p_bxbx, p_byby;
   logic signed [DOT_BITS-1:0]   len_a_sum, len_b_sum;

   assign req_ch.ready = !s1_valid_ff || cmd_ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign bx = $signed({1'b0, req_ch.vertex_x}) - $signed({1'b0, prev_vx_ff});
   assign by = $signed({1'b0, req_ch.vertex_y}) - $signed({1'b0, prev_vy_ff});

   always_comb begin
      if (count_ff == '0) begin
         cls = CLS_FIRST;
      end else if (count_ff == INDEX_BITS'(1)) begin
         cls = CLS_SECOND;
      end else begin
         cls = CLS_TURN;
      end
   end

   always_comb begin
      prev_vx_in  = prev_vx_ff;
      prev_vy_in  = prev_vy_ff;
      prev_dx_in  = prev_dx_ff;
      prev_dy_in  = prev_dy_ff;
      count_in    = count_ff;
      s1_valid_in = s1_valid_ff && !cmd_ready;
      if (accept) begin
         s1_valid_in = 1'b1;
         if (req_ch.last_vertex) begin
            prev_vx_in = '0;
            prev_vy_in = '0;
            prev_dx_in = '0;
            prev_dy_in = '0;
            count_in   = '0;
         end else begin
            if (cls != CLS_FIRST) begin
               prev_dx_in = bx;
               prev_dy_in = by;
            end
            prev_vx_in = req_ch.vertex_x;
            prev_vy_in = req_ch.vertex_y;
            // The index saturates on very long contours.
            if (count_ff != '1) begin
               count_in = count_ff + INDEX_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_vx_ff  <= '0;
         prev_vy_ff  <= '0;
         prev_dx_ff  <= '0;
         prev_dy_ff  <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         prev_vx_ff  <= prev_vx_in;
         prev_vy_ff  <= prev_vy_in;
         prev_dx_ff  <= prev_dx_in;
         prev_dy_ff  <= prev_dy_in;
         count_ff    <= count_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ax_ff   <= prev_dx_ff;
         s1_ay_ff   <= prev_dy_ff;
         s1_bx_ff   <= bx;
         s1_by_ff   <= by;
         s1_k_ff    <= count_ff;
         s1_cls_ff  <= cls;
         s1_last_ff <= req_ch.last_vertex;
      end
   end

   // Edge products; the queue entry registers them.
   assign p_axbx = s1_ax_ff * s1_bx_ff;
   assign p_ayby = s1_ay_ff * s1_by_ff;
   assign p_axby = s1_ax_ff * s1_by_ff;
   assign p_aybx = s1_ay_ff * s1_bx_ff;
   assign p_axax = s1_ax_ff * s1_ax_ff;
   assign p_ayay = s1_ay_ff * s1_ay_ff;
   assign p_bxbx = s1_bx_ff * s1_bx_ff;
   assign p_byby = s1_by_ff * s1_by_ff;

   assign len_a_sum = DOT_BITS'(p_axax) + DOT_BITS'(p_ayay);
   assign len_b_sum = DOT_BITS'(p_bxbx) + DOT_BITS'(p_byby);

   assign cmd_valid = s1_valid_ff;
   assign cmd.dot   = DOT_BITS'(p_axbx) + DOT_BITS'(p_ayby);
   assign cmd.crs   = DOT_BITS'(p_axby) - DOT_BITS'(p_aybx);
   assign cmd.len_a = len_a_sum[LEN_BITS-1:0];
   assign cmd.len_b = len_b_sum[LEN_BITS-1:0];
   assign cmd.k     = s1_k_ff;
   assign cmd.cls   = s1_cls_ff;
   assign cmd.last  = s1_last_ff;
endmodule

/* hdl/pas_cmd_queue.sv */
// Short queue of classified vertex commands between front and back end.
module pas_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  pas_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop,
   output pas_pkg::cmd_type pop_data
);
   import pas_pkg::*;

   cmd_type                   entry_ff [CMD_DEPTH];
   logic [CMD_PTR_BITS-1:0]   wr_ff, wr_in;
   logic [CMD_PTR_BITS-1:0]   rd_ff, rd_in;
   logic [CMD_COUNT_BITS-1:0] count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign push_ready = count_ff != CMD_COUNT_BITS'(CMD_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = entry_ff[rd_ff];

   always_comb begin
      wr_in    = do_push ? wr_ff + CMD_PTR_BITS'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + CMD_PTR_BITS'(1) : rd_ff;
      count_in = count_ff + CMD_COUNT_BITS'(do_push) - CMD_COUNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end
endmodule

/* hdl/pas_back.sv */
// Back end: angle and length tests, arc tracking and the segment output buffer.
module pas_back (
   input  logic             clock,
   input  logic             reset,
   input  pas_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  pas_pkg::cmd_type cmd,
   pas_rsp_if.source        rsp_ch
);
   import pas_pkg::*;

   bk_state_type              state_ff, state_in;
   cmd_type                   work_ff;
   logic [COT_PROD_BITS-1:0]  cot_prod_ff;
   logic [LO_BITS-1:0]        lo_ff;
   logic [HI_BITS-1:0]        hi_ff;

   logic [INDEX_BITS-1:0]     open_start_ff, open_start_in;
   logic                      in_arc_ff, in_arc_in;
   logic                      arc_turn_ff, arc_turn_in;

   seg_type                   out_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0]   out_wr_ff, out_wr_in;
   logic [OUT_PTR_BITS-1:0]   out_rd_ff, out_rd_in;
   logic [OUT_COUNT_BITS-1:0] out_count_ff, out_count_in;

   logic                      out_room;
   logic                      out_pop;
   logic                      dec_fire;
   logic                      crs_neg, crs_pos, len_a_zero, angle_ok;
   logic                      pair_ok, arc_ok;
   logic [DOT_BITS-1:0]       crs_negated;
   logic [LEN_BITS-1:0]       abs_c;
   logic [CMP_BITS-1:0]       lhs, m, lo, hi;
   logic [INDEX_BITS-1:0]     p_idx;
   logic signed [1:0]         arc_dir;
   logic [1:0]                n_push;
   seg_type                   seg0, seg1;

   function automatic seg_type make_seg(input logic [INDEX_BITS-1:0] s,
                                        input logic [INDEX_BITS-1:0] e,
                                        input logic signed [1:0] dir,
                                        input logic last);
      seg_type r;
      r.seg_start = SEG_BITS'(s);
      r.seg_end   = SEG_BITS'(e);
      r.seg_dir   = dir;
      r.seg_last  = last;
      return r;
   endfunction

   // Sequencer: a product state, then a decision state that waits for room in the output buffer.
   assign out_room = out_count_ff <= OUT_COUNT_BITS'(OUT_DEPTH - 2);

   always_comb begin
      state_in = state_ff;
      cmd_pop  = 1'b0;
      dec_fire = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            state_in = BK_DEC;
         end
         BK_DEC: begin
            if (out_room) begin
               dec_fire = 1'b1;
               if (cmd_valid) begin
                  cmd_pop  = 1'b1;
                  state_in = BK_MUL;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign crs_neg     = work_ff.crs[DOT_BITS-1];
   assign crs_pos     = !crs_neg && (work_ff.crs != '0);
   assign crs_negated = -work_ff.crs;
   assign abs_c       = crs_neg ? crs_negated[LEN_BITS-1:0] : work_ff.crs[LEN_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         work_ff <= cmd;
      end
      if (state_ff == BK_MUL) begin
         cot_prod_ff <= cfg.cot * abs_c;
         lo_ff       <= cfg.inv_ratio * work_ff.len_a;
         hi_ff       <= cfg.len_ratio * work_ff.len_a;
      end
   end

   // The angle test only passes for a positive dot product, so the
   // magnitude bits suffice once the sign is checked.
   assign lhs        = CMP_BITS'({work_ff.dot[DOT_BITS-2:0], {FRAC_BITS{1'b0}}});
   assign m          = CMP_BITS'({work_ff.len_b, {FRAC_BITS{1'b0}}});
   assign lo         = CMP_BITS'(lo_ff);
   assign hi         = CMP_BITS'(hi_ff);
   assign len_a_zero = work_ff.len_a == '0;
   assign angle_ok   = !work_ff.dot[DOT_BITS-1] && (lhs > CMP_BITS'(cot_prod_ff));
   assign pair_ok    = !len_a_zero && (work_ff.crs != '0) && angle_ok && (lo <= m) && (m <= hi);
   assign arc_ok     = !len_a_zero && (arc_turn_ff ? crs_pos : crs_neg) && angle_ok
                       && (lo < m) && (m < hi);
   assign p_idx      = work_ff.k - INDEX_BITS'(1);
   assign arc_dir    = arc_turn_ff ? DIR_POS : DIR_NEG;

   always_comb begin
      open_start_in = open_start_ff;
      in_arc_in     = in_arc_ff;
      arc_turn_in   = arc_turn_ff;
      n_push        = 2'd0;
      seg0          = make_seg('0, '0, DIR_NONE, 1'b0);
      seg1          = make_seg(p_idx, work_ff.k, DIR_NONE, 1'b1);
      if (dec_fire) begin
         case (work_ff.cls)
            CLS_FIRST: begin
            end
            CLS_SECOND: begin
               open_start_in = '0;
               in_arc_in     = 1'b0;
               if (work_ff.last) begin
                  seg0   = make_seg('0, INDEX_BITS'(1), DIR_NONE, 1'b1);
                  n_push = 2'd1;
               end
            end
            CLS_TURN: begin
               if (!in_arc_ff) begin
                  if (pair_ok) begin
                     arc_turn_in = crs_pos;
                     in_arc_in   = 1'b1;
                     if (work_ff.last) begin
                        seg0   = make_seg(open_start_ff, work_ff.k,
                                          crs_pos ? DIR_POS : DIR_NEG, 1'b1);
                        n_push = 2'd1;
                     end
                  end else begin
                     seg0          = make_seg(open_start_ff, p_idx, DIR_NONE, 1'b0);
                     open_start_in = p_idx;
                     n_push        = work_ff.last ? 2'd2 : 2'd1;
                  end
               end else begin
                  if (arc_ok) begin
                     if (work_ff.last) begin
                        seg0   = make_seg(open_start_ff, work_ff.k, arc_dir, 1'b1);
                        n_push = 2'd1;
                     end
                  end else begin
                     seg0          = make_seg(open_start_ff, p_idx, arc_dir, 1'b0);
                     open_start_in = p_idx;
                     in_arc_in     = 1'b0;
                     n_push        = work_ff.last ? 2'd2 : 2'd1;
                  end
               end
            end
            default: begin
            end
         endcase
         if (work_ff.last) begin
            open_start_in = '0;
            in_arc_in     = 1'b0;
            arc_turn_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_start_ff <= '0;
         in_arc_ff     <= 1'b0;
         arc_turn_ff   <= 1'b0;
      end else begin
         open_start_ff <= open_start_in;
         in_arc_ff     <= in_arc_in;
         arc_turn_ff   <= arc_turn_in;
      end
   end

   // Output buffer.
   assign out_pop = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      out_wr_in    = out_wr_ff + OUT_PTR_BITS'(n_push);
      out_rd_in    = out_pop ? out_rd_ff + OUT_PTR_BITS'(1) : out_rd_ff;
      out_count_in = out_count_ff + OUT_COUNT_BITS'(n_push) - OUT_COUNT_BITS'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         out_mem_ff[out_wr_ff] <= seg0;
      end
      if (n_push == 2'd2) begin
         out_mem_ff[out_wr_ff + OUT_PTR_BITS'(1)] <= seg1;
      end
   end

   assign rsp_ch.valid     = out_count_ff != '0;
   assign rsp_ch.seg_start = out_mem_ff[out_rd_ff].seg_start;
   assign rsp_ch.seg_end   = out_mem_ff[out_rd_ff].seg_end;
   assign rsp_ch.seg_dir   = out_mem_ff[out_rd_ff].seg_dir;
   assign rsp_ch.seg_last  = out_mem_ff[out_rd_ff].seg_last;
endmodule

/* hdl/polygon_arc_segmenter_core.sv */
// Top level of the polygon arc segmenter: configuration registers and block wiring.
`include "polygon_arc_segmenter_core_macros.svh"

// The block takes the vertices of one simplified contour, one word per
// vertex, and splits them into segments that share their end vertices.
// Each new edge is compared with the previous one by dot and cross product
// against the cotangent limit and the squared length ratio bounds; runs of
// vertices that turn the same way become arcs with direction +1 or -1, and
// pairs that fail the test come out as plain segments with direction 0.
// A vertex marked last closes the contour and the next vertex starts again
// at index 0. One vertex word yields zero, one or two segment words, in
// order. The back end forms the ratio and angle products in one state and
// decides in the next, taking the next vertex command as it decides; the
// decision waits until the four-word segment buffer has two free places.
// Between an accepted vertex and its first segment word lie the front-end
// edge registers, the command queue entry, the back-end work register,
// the product registers and the segment buffer. A short command queue
// between the edge front end and the decision back end lets vertices keep
// arriving while segment words are held up. The user must write the three
// configuration registers through the csr port while the block is idle,
// which the block itself leaves to the user; they take effect for the next vertex.
module polygon_arc_segmenter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   pas_req_if.sink                              req_ch,
   pas_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic [pas_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pas_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import pas_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic    cmd_push_valid;
   logic    cmd_push_ready;
   cmd_type cmd_push_data;
   logic    cmd_pop_valid;
   logic    cmd_pop;
   cmd_type cmd_pop_data;

   // Configuration registers. Writes to an index beyond the last register
   // are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COT: begin
               cfg_in.cot = csr_wdata[COT_BITS-1:0];
            end
            CSR_LEN_RATIO: begin
               cfg_in.len_ratio = csr_wdata[LEN_RATIO_BITS-1:0];
            end
            CSR_INV_RATIO: begin
               cfg_in.inv_ratio = csr_wdata[INV_RATIO_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cot       <= COT_RESET;
         cfg_ff.len_ratio <= LEN_RATIO_RESET;
         cfg_ff.inv_ratio <= INV_RATIO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end keeps the previous vertex, edge and index, classifies
   // each vertex by its place in the contour and forms the edge products.
   pas_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_push_valid),
      .cmd       (cmd_push_data),
      .cmd_ready (cmd_push_ready)
   );

   pas_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_push_valid),
      .push_ready (cmd_push_ready),
      .push_data  (cmd_push_data),
      .pop_valid  (cmd_pop_valid),
      .pop        (cmd_pop),
      .pop_data   (cmd_pop_data)
   );

   // The back end holds the open arc and emits the segment words.
   pas_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_pop_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd_pop_data),
      .rsp_ch    (rsp_ch)
   );

   // No segment word is offered in the cycle after reset.
   `PAS_ASSERT_ALWAYS(a_quiet_after_reset, reset |=> !rsp_ch.valid, "segment word right after reset")
   // Direction is always +1, -1 or 0.
   `PAS_ASSERT(a_dir_legal, rsp_ch.valid |-> rsp_ch.seg_dir != DIR_BAD, "illegal segment direction")
   // Configuration only changes through a register write.
   `PAS_ASSERT(a_cfg_held, !csr_we |=> $stable(cfg_ff), "configuration changed without a write")
endmodule

/* test/polygon_arc_segmenter_core_checker.sv */
// Checker for the polygon arc segmenter: predicts segment words and compares them.
module polygon_arc_segmenter_core_checker (
   input  logic                               clock,
   input  logic                               reset,
   pas_req_if                                 req_mon,
   pas_rsp_if                                 rsp_mon,
   input  logic                               csr_we,
   input  logic [pas_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pas_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int unsigned                        segs_owed,
   output int unsigned                        fault_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import pas_pkg::*;

   // Shadow copy of the configuration registers.
   logic [COT_BITS-1:0]       cot_limit;
   logic [LEN_RATIO_BITS-1:0] ratio_ceiling;
   logic [INV_RATIO_BITS-1:0] ratio_floor;

   // Shadow copy of the contour walk.
   logic [COORD_BITS-1:0]       last_x;
   logic [COORD_BITS-1:0]       last_y;
   logic signed [EDGE_BITS-1:0] edge_dx;
   logic signed [EDGE_BITS-1:0] edge_dy;
   logic [INDEX_BITS-1:0]       vtx_count;
   logic [INDEX_BITS-1:0]       run_start;
   logic                        arc_open;
   logic                        turn_left;

   seg_type     segs_due[$];
   seg_type     want;
   int unsigned faults = 0;

   // Angle and length-ratio test between edge a and edge b. A sense of zero takes the
   // magnitude of the cross product with inclusive bounds; +1 or -1 keeps the sign of the
   // open arc and uses strict bounds.
   function automatic bit turn_passes(longint ax, longint ay, longint bx, longint by,
                                      int sense);
      longint len_a, dot, crs, mag_b, lo, hi;
      len_a = ax * ax + ay * ay;
      if (len_a == 0) return 1'b0;
      dot = ax * bx + ay * by;
      crs = ax * by - ay * bx;
      if (sense == 0 && crs < 0) crs = -crs;
      else if (sense < 0) crs = -crs;
      if (crs <= 0) return 1'b0;
      if (dot * 65536 <= longint'(cot_limit) * crs) return 1'b0;
      mag_b = (bx * bx + by * by) * 65536;
      lo    = longint'(ratio_floor) * len_a;
      hi    = longint'(ratio_ceiling) * len_a;
      if (sense == 0) return (lo <= mag_b) && (mag_b <= hi);
      return (lo < mag_b) && (mag_b < hi);
   endfunction

   function automatic void owe(logic [INDEX_BITS-1:0] s, logic [INDEX_BITS-1:0] e,
                               logic signed [1:0] dir, logic tail);
      seg_type w;
      w.seg_start = SEG_BITS'(s);
      w.seg_end   = SEG_BITS'(e);
      w.seg_dir   = dir;
      w.seg_last  = tail;
      segs_due.insert(segs_due.size(), w);
   endfunction

   function automatic void clear_contour();
      last_x    = '0;
      last_y    = '0;
      edge_dx   = '0;
      edge_dy   = '0;
      vtx_count = '0;
      run_start = '0;
      arc_open  = 1'b0;
      turn_left = 1'b0;
   endfunction

   // Works out the segment words that one accepted vertex releases.
   function automatic void segment_vertex(logic [COORD_BITS-1:0] x,
                                          logic [COORD_BITS-1:0] y, logic tail);
      logic [INDEX_BITS-1:0] k, p;
      longint                bx, by, crs;
      logic signed [1:0]     arc_dir;
      k  = vtx_count;
      p  = k - 1'b1;
      bx = longint'(x) - longint'(last_x);
      by = longint'(y) - longint'(last_y);
      arc_dir = turn_left ? DIR_POS : DIR_NEG;
      if (k == 1) begin
         run_start = '0;
         arc_open  = 1'b0;
         if (tail) owe('0, INDEX_BITS'(1), DIR_NONE, 1'b1);
      end else if (k >= 2 && !arc_open) begin
         if (turn_passes(edge_dx, edge_dy, bx, by, 0)) begin
            crs       = longint'(edge_dx) * by - longint'(edge_dy) * bx;
            turn_left = crs > 0;
            arc_open  = 1'b1;
            if (tail) owe(run_start, k, turn_left ? DIR_POS : DIR_NEG, 1'b1);
         end else begin
            owe(run_start, p, DIR_NONE, 1'b0);
            run_start = p;
            if (tail) owe(p, k, DIR_NONE, 1'b1);
         end
      end else if (k >= 2) begin
         if (turn_passes(edge_dx, edge_dy, bx, by, turn_left ? 1 : -1)) begin
            if (tail) owe(run_start, k, arc_dir, 1'b1);
         end else begin
            owe(run_start, p, arc_dir, 1'b0);
            run_start = p;
            arc_open  = 1'b0;
            if (tail) owe(p, k, DIR_NONE, 1'b1);
         end
      end
      if (tail) begin
         clear_contour();
      end else begin
         if (k >= 1) begin
            edge_dx = EDGE_BITS'(bx);
            edge_dy = EDGE_BITS'(by);
         end
         last_x = x;
         last_y = y;
         if (vtx_count != {INDEX_BITS{1'b1}}) vtx_count = vtx_count + 1'b1;
      end
   endfunction

   function automatic void check_field(string name, int want_v, int got_v);
      if (want_v != got_v) begin
         faults++;
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cot_limit     = COT_RESET;
         ratio_ceiling = LEN_RATIO_RESET;
         ratio_floor   = INV_RATIO_RESET;
         clear_contour();
         segs_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_COT:       cot_limit     = csr_wdata[COT_BITS-1:0];
               CSR_LEN_RATIO: ratio_ceiling = csr_wdata[LEN_RATIO_BITS-1:0];
               CSR_INV_RATIO: ratio_floor   = csr_wdata[INV_RATIO_BITS-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            segment_vertex(req_mon.vertex_x, req_mon.vertex_y, req_mon.last_vertex);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (segs_due.size() == 0) begin
               faults++;
               $error("segment word with nothing expected: start %0d end %0d dir %0d",
                      rsp_mon.seg_start, rsp_mon.seg_end, rsp_mon.seg_dir);
            end else begin
               want = segs_due.pop_front();
               check_field("seg_start", int'(want.seg_start), int'(rsp_mon.seg_start));
               check_field("seg_end", int'(want.seg_end), int'(rsp_mon.seg_end));
               check_field("seg_dir", int'(want.seg_dir), int'(rsp_mon.seg_dir));
               check_field("seg_last", int'(want.seg_last), int'(rsp_mon.seg_last));
            end
         end
      end
      segs_owed   <= segs_due.size();
      fault_count <= faults;
   end

endmodule

/* test/polygon_arc_segmenter_core_test.sv */
// Top of the polygon arc segmenter testbench: clock, reset, stimulus and verdict.
module polygon_arc_segmenter_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import pas_pkg::*;

   localparam real PI          = 3.14159265358979;
   localparam int  LONG_WORDS  = 64;
   localparam int  COORD_TOP   = (1 << COORD_BITS) - 1;

   // Opening words: a lone vertex, a two-vertex contour across the extremes, repeated
   // vertices, a left-turning arc, a right-turning arc broken by a reversed turn, the four
   // corners of the coordinate range, and a straight run ending in a very long edge.
   localparam int unsigned OPENING [25][3] = '{
      '{2048, 2048, 1},
      '{4095, 4095, 0}, '{0, 0, 1},
      '{100, 100, 0}, '{100, 100, 0}, '{200, 100, 0}, '{200, 100, 1},
      '{1000, 1000, 0}, '{1100, 1000, 0}, '{1170, 1070, 0}, '{1170, 1170, 0},
      '{1100, 1240, 1},
      '{3000, 3000, 0}, '{3100, 3000, 0}, '{3170, 2930, 0}, '{3170, 2830, 0},
      '{3270, 2830, 1},
      '{0, 4095, 0}, '{4095, 0, 0}, '{0, 0, 0}, '{4095, 4095, 1},
      '{0, 0, 0}, '{10, 0, 0}, '{20, 0, 0}, '{4095, 0, 1}
   };

   logic clock;
   logic reset = 1'b1;

   // Driven copies of the block's inputs; every one starts at a known value.
   logic                      vtx_valid  = 1'b0;
   logic [COORD_BITS-1:0]     vtx_x      = '0;
   logic [COORD_BITS-1:0]     vtx_y      = '0;
   logic                      vtx_last   = 1'b0;
   logic                      take_ready = 1'b0;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_idx    = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   // When set, neither side idles: the sender offers back-to-back words and the segment
   // sink never stalls.
   bit          steady     = 1'b0;
   int          stall_left = 0;
   int          sink_roll;
   int unsigned words_sent = 0;
   int unsigned segs_owed;
   int unsigned fault_count;

   pas_req_if req_ch ();
   pas_rsp_if rsp_ch ();

   assign req_ch.valid       = vtx_valid;
   assign req_ch.vertex_x    = vtx_x;
   assign req_ch.vertex_y    = vtx_y;
   assign req_ch.last_vertex = vtx_last;
   assign rsp_ch.ready       = take_ready;

   polygon_arc_segmenter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_idx),
      .csr_wdata (csr_data)
   );

   polygon_arc_segmenter_core_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_idx),
      .csr_wdata   (csr_data),
      .segs_owed   (segs_owed),
      .fault_count (fault_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Segment sink pacing. Most cycles take a word; the others stall, and now and then
   // for a long stretch, so that the segment buffer fills and the vertex side
   // is pushed back through the command queue.
   always @(posedge clock) begin
      if (steady) begin
         take_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         take_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         sink_roll = $urandom_range(0, 99);
         if (sink_roll < 70) begin
            take_ready <= 1'b1;
         end else begin
            take_ready <= 1'b0;
            stall_left <= (sink_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 60);
         end
      end
   end

   // Idle cycles before the next vertex word: mostly none or a few, now and then a long
   // one, so that gaps land in both the product and the decision state of the back end.
   function automatic int next_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [COORD_BITS-1:0] to_coord(real v);
      if (v < 0.0) return '0;
      if (v > real'(COORD_TOP)) return COORD_BITS'(COORD_TOP);
      return COORD_BITS'($rtoi(v));
   endfunction

   // Offers one vertex word and returns at the clock edge where it is taken. Valid is
   // only lowered for a gap before the word, so it is never dropped and raised in one step.
   task automatic send_vertex(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                              input logic tail);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         vtx_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      vtx_valid <= 1'b1;
      vtx_x     <= x;
      vtx_y     <= y;
      vtx_last  <= tail;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   // Waits until every predicted segment word has arrived. The first edge is always
   // waited for, so that a vertex taken at the current edge is already counted.
   task automatic settle(input int extra);
      do @(posedge clock); while (segs_owed != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_we   <= 1'b1;
      csr_idx  <= idx;
      csr_data <= value;
      @(posedge clock);
   endtask

   // A contour of points on a circle or a gentle spiral. The turn sense may reverse part
   // way round, the radius may jump to break the length-ratio bound, and the odd vertex
   // is jittered or repeated. Large steps push the turn past the angle limit.
   task automatic send_arc_contour();
      real cx, cy, rad, ang, step, grow;
      int  count, i, flip_at, sense;
      logic [COORD_BITS-1:0] x, y;
      count   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(3, 14);
      cx      = $urandom_range(0, COORD_TOP);
      cy      = $urandom_range(0, COORD_TOP);
      rad     = $urandom_range(8, 1500);
      step    = real'($urandom_range(3, 70)) * PI / 180.0;
      ang     = real'($urandom_range(0, 359)) * PI / 180.0;
      sense   = $urandom_range(0, 1) ? 1 : -1;
      flip_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, count - 1)) : -1;
      grow    = ($urandom_range(0, 3) == 0) ?
                1.0 + real'(int'($urandom_range(0, 40)) - 20) / 100.0 : 1.0;
      for (i = 0; i < count; i++) begin
         if (i == flip_at) sense = -sense;
         x = to_coord(cx + rad * $cos(ang));
         y = to_coord(cy + rad * $sin(ang));
         if ($urandom_range(0, 19) == 0) begin
            x = to_coord(real'(x) + real'(int'($urandom_range(0, 6)) - 3));
            y = to_coord(real'(y) + real'(int'($urandom_range(0, 6)) - 3));
         end
         send_vertex(x, y, i == count - 1);
         // An occasional vertex is sent twice by not moving on.
         if ($urandom_range(0, 39) != 0) ang = ang + real'(sense) * step;
         rad = rad * grow;
         if ($urandom_range(0, 29) == 0) rad = rad * ($urandom_range(0, 1) ? 5.0 : 0.2);
      end
   endtask

   // A short contour of loosely related points: fully random, close to the previous
   // vertex, a repeat of it, or on the edge of the coordinate range.
   task automatic send_noise_contour();
      int count, i, roll;
      logic [COORD_BITS-1:0] x, y;
      count = $urandom_range(1, 8);
      x     = COORD_BITS'($urandom_range(0, COORD_TOP));
      y     = COORD_BITS'($urandom_range(0, COORD_TOP));
      for (i = 0; i < count; i++) begin
         roll = $urandom_range(0, 9);
         if (roll < 5) begin
            x = COORD_BITS'($urandom_range(0, COORD_TOP));
            y = COORD_BITS'($urandom_range(0, COORD_TOP));
         end else if (roll < 8) begin
            x = to_coord(real'(x) + real'(int'($urandom_range(0, 80)) - 40));
            y = to_coord(real'(y) + real'(int'($urandom_range(0, 80)) - 40));
         end else if (roll == 9) begin
            x = $urandom_range(0, 1) ? COORD_BITS'(COORD_TOP) : '0;
            y = $urandom_range(0, 1) ? COORD_BITS'(COORD_TOP) : '0;
         end
         send_vertex(x, y, i == count - 1);
      end
   endtask

   // Random contours until the word budget is spent. Once, half way, the sender holds
   // off until the block has delivered every segment word owed so far.
   task automatic run_random(input int budget);
      int unsigned goal, pause_at;
      bit          paused;
      goal     = words_sent + budget;
      pause_at = words_sent + budget / 2;
      paused   = 1'b0;
      while (words_sent < goal) begin
         steady = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 3) != 0) send_arc_contour();
         else send_noise_contour();
         if (!paused && words_sent >= pause_at) begin
            vtx_valid <= 1'b0;
            settle(0);
            paused = 1'b1;
         end
      end
      steady = 1'b0;
   endtask

   // One longer contour sent with no idling on either side. The path wanders with a
   // turn bias that changes now and then, so it holds arcs of both senses as well as
   // plain pairs, and it turns back at the edges of the coordinate range.
   task automatic send_long_contour();
      real px, py, heading, reach, bias;
      int  i;
      steady  = 1'b1;
      px      = 2048.0;
      py      = 2048.0;
      heading = 0.0;
      bias    = 15.0;
      for (i = 0; i < LONG_WORDS; i++) begin
         send_vertex(to_coord(px), to_coord(py), i == LONG_WORDS - 1);
         if ($urandom_range(0, 15) == 0) bias = -bias;
         heading = heading + (bias + real'(int'($urandom_range(0, 30)) - 15)) * PI / 180.0;
         reach   = $urandom_range(4, 40);
         px      = px + reach * $cos(heading);
         py      = py + reach * $sin(heading);
         if (px < 0.0 || px > real'(COORD_TOP) || py < 0.0 || py > real'(COORD_TOP)) begin
            px      = real'(to_coord(px));
            py      = real'(to_coord(py));
            heading = heading + PI;
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      logic [COT_BITS-1:0]       cot_v;
      logic [LEN_RATIO_BITS-1:0] len_v;
      logic [INV_RATIO_BITS-1:0] inv_v;
      int                        ph, i;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // The opening words and the first random stretch run on the reset settings.
      for (i = 0; i < 25; i++)
         send_vertex(COORD_BITS'(OPENING[i][0]), COORD_BITS'(OPENING[i][1]),
                     OPENING[i][2][0]);
      run_random(200);

      // Each later stretch starts from an idle block with new register settings: the
      // loosest, the tightest, a narrow band, two random ones and the reset values again.
      for (ph = 0; ph < 6; ph++) begin
         vtx_valid <= 1'b0;
         settle(20);
         case (ph)
            0: begin
               cot_v = '0;
               len_v = '1;
               inv_v = '0;
            end
            1: begin
               cot_v = '1;
               len_v = '0;
               inv_v = '1;
            end
            2: begin
               cot_v = 22'd113512;
               len_v = 24'd131072;
               inv_v = 17'd32768;
            end
            3: begin
               cot_v = COT_BITS'($urandom_range(0, 300000));
               len_v = LEN_RATIO_BITS'($urandom_range(65536, 16777215));
               inv_v = INV_RATIO_BITS'($urandom_range(0, 65536));
            end
            4: begin
               cot_v = COT_BITS'($urandom);
               len_v = LEN_RATIO_BITS'($urandom);
               inv_v = INV_RATIO_BITS'($urandom);
            end
            default: begin
               cot_v = COT_RESET;
               len_v = LEN_RATIO_RESET;
               inv_v = INV_RATIO_RESET;
            end
         endcase
         write_csr(CSR_COT, CSR_DATA_BITS'(cot_v));
         write_csr(CSR_LEN_RATIO, CSR_DATA_BITS'(len_v));
         write_csr(CSR_INV_RATIO, CSR_DATA_BITS'(inv_v));
         csr_we <= 1'b0;
         run_random(190);
      end

      send_long_contour();

      vtx_valid <= 1'b0;
      settle(40);
      if (fault_count == 0 && segs_owed == 0) begin
         $display("polygon_arc_segmenter_core_test: done, clean");
      end else begin
         $display("polygon_arc_segmenter_core_test: done, errors");
      end
      $finish;
   end

   // Run limit, several times the slowest correct run.
   initial begin
      #(12_000_000);
      $display("polygon_arc_segmenter_core_test: done, errors");
      $finish;
   end

endmodule
